// ----- sv/cba_pkg.sv -----
// ----------------------------------------------------------------------------
// cba_pkg
// shared types and codes for the contiguous block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] REG_BLOCK_COUNT  = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;
    localparam logic [1:0] REG_BASE_ADDRESS = 2'd2;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_RELEASE,
        OP_CLEAR,
        OP_BAD
    } op_t;

endpackage

`default_nettype wire

// ----- sv/cba_front.sv -----
// ----------------------------------------------------------------------------
// cba_front
// classifies a command and turns request bytes into a block count
// ----------------------------------------------------------------------------
`default_nettype none

module cba_front
    import cba_pkg::*;
#(
    parameter int TAG_BITS = 16,
    parameter int CW       = 11
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     front_busy,
    input  wire logic [1:0]          command,
    input  wire logic [15:0]         owner_tag,
    input  wire logic [23:0]         request_bytes,
    input  wire logic [6:0]          block_count,
    input  wire logic [15:0]         block_size,
    input  wire logic                q_full,
    output logic                     q_push,
    output op_t                      q_op,
    output logic [TAG_BITS-1:0]      q_tag,
    output logic [CW-1:0]            q_need
);

    typedef enum logic [1:0] { S_IDLE, S_DIV, S_PUSH } state_t;

    state_t              state_reg;
    logic [23:0]         quo_reg;
    logic [16:0]         rem_reg;
    logic [4:0]          cnt_reg;
    logic [15:0]         dsr_reg;
    op_t                 op_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic [TAG_BITS-1:0] tag_in;
    logic                tag_zero;
    logic [16:0]         rem_shift;
    logic [24:0]         need_full;

    // tag kept in its low TAG_BITS bits
    always_comb
    begin
        tag_in = '0;
        for (int b = 0; b < TAG_BITS; b++)
        begin
            if (b < 16)
            begin
                tag_in[b] = owner_tag[b];
            end
        end
    end

    assign tag_zero  = (tag_in == '0);
    assign rem_shift = {rem_reg[15:0], quo_reg[23]};
    // ceiling: quotient plus one when a remainder is left
    assign need_full = {1'b0, quo_reg} + {24'd0, (rem_reg != 17'd0)};

    assign front_busy = (state_reg != S_IDLE);
    assign q_push     = (state_reg == S_PUSH) && !q_full;
    assign q_op       = op_reg;
    assign q_tag      = tag_reg;
    // saturate so oversized requests stay oversized
    assign q_need     = (need_full > 25'((1 << CW) - 1)) ? CW'((1 << CW) - 1)
                                                        : need_full[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            op_reg    <= OP_BAD;
            tag_reg   <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            dsr_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        tag_reg <= tag_in;
                        quo_reg <= request_bytes;
                        rem_reg <= '0;
                        dsr_reg <= block_size;
                        cnt_reg <= '0;
                        unique case (command)
                            CMD_ALLOC:
                            begin
                                if (request_bytes != '0 && !tag_zero &&
                                    block_size != '0 && block_count != '0)
                                begin
                                    op_reg    <= OP_ALLOC;
                                    state_reg <= S_DIV;
                                end
                                else
                                begin
                                    op_reg    <= OP_BAD;
                                    state_reg <= S_PUSH;
                                end
                            end
                            CMD_RELEASE:
                            begin
                                op_reg <= (!tag_zero && block_size != '0 &&
                                           block_count != '0) ? OP_RELEASE : OP_BAD;
                                state_reg <= S_PUSH;
                            end
                            CMD_CLEAR:
                            begin
                                op_reg    <= OP_CLEAR;
                                state_reg <= S_PUSH;
                            end
                            default:
                            begin
                                op_reg    <= OP_BAD;
                                state_reg <= S_PUSH;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit a cycle
                    if (rem_shift >= {1'b0, dsr_reg})
                    begin
                        rem_reg <= rem_shift - {1'b0, dsr_reg};
                        quo_reg <= {quo_reg[22:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[22:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd23)
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/cba_queue.sv -----
// ----------------------------------------------------------------------------
// cba_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module cba_queue
    import cba_pkg::*;
#(
    parameter int W = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              not_empty,
    output logic [W-1:0]      pop_data
);

    logic [W-1:0] mem_reg [2];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

// ----- sv/cba_back.sv -----
// ----------------------------------------------------------------------------
// cba_back
// scans block marks for a first-fit run and updates the pool
// ----------------------------------------------------------------------------
`default_nettype none

module cba_back
    import cba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64,
    parameter int TAG_BITS   = 16,
    parameter int CW         = 11
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    output logic                     q_pop,
    input  wire op_t                 q_op,
    input  wire logic [TAG_BITS-1:0] q_tag,
    input  wire logic [CW-1:0]       q_need,
    input  wire logic [6:0]          block_count,
    input  wire logic [15:0]         block_size,
    input  wire logic [31:0]         base_address,
    output logic                     back_busy,
    output logic                     done,
    output logic [1:0]               status,
    output logic [31:0]              address,
    output logic [5:0]               first_block
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    typedef enum logic [2:0] { S_IDLE, S_SCAN, S_MARK, S_MUL, S_SWEEP } state_t;

    state_t              state_reg;
    logic [MAX_BLOCKS-1:0] used_reg;
    logic [TAG_BITS-1:0] owner_reg [MAX_BLOCKS];
    logic [TAG_BITS-1:0] owner_rd_reg;
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       run_reg;
    logic [CW-1:0]       first_reg;
    logic [CW-1:0]       last_reg;
    logic [CW-1:0]       limit_reg;
    logic [CW-1:0]       need_reg;
    logic [TAG_BITS-1:0] tag_reg;
    op_t                 op_reg;
    logic [31:0]         prod_reg;
    logic                done_reg;
    logic [1:0]          status_reg;
    logic [31:0]         address_reg;
    logic [5:0]          first_block_reg;

    logic [IW-1:0]       idx_i;
    logic [IW-1:0]       rd_idx;
    logic                sweep_hit;
    logic [CW-1:0]       limit_in;
    logic [CW-1:0]       run_inc;

    assign idx_i    = idx_reg[IW-1:0];
    assign run_inc  = run_reg + CW'(1);
    // oversized pools are taken as MAX_BLOCKS
    assign limit_in = (CW'(block_count) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                          : CW'(block_count);

    // owner read port is registered: a sweep reads one entry ahead, idle reads entry 0
    assign rd_idx    = (state_reg == S_SWEEP && idx_reg != CW'(MAX_BLOCKS - 1))
                       ? IW'(idx_reg + CW'(1)) : '0;
    assign sweep_hit = (op_reg == OP_CLEAR) ||
                       (used_reg[idx_i] && owner_rd_reg == tag_reg);

    assign q_pop       = (state_reg == S_IDLE) && q_valid;
    assign back_busy   = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign address     = address_reg;
    assign first_block = first_block_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MARK)
        begin
            owner_reg[idx_i] <= tag_reg;
        end
        else if (state_reg == S_SWEEP && sweep_hit)
        begin
            owner_reg[idx_i] <= '0;
        end
        owner_rd_reg <= owner_reg[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            used_reg        <= '0;
            done_reg        <= 1'b0;
            status_reg      <= ST_DONE;
            address_reg     <= '0;
            first_block_reg <= '0;
            idx_reg         <= '0;
            run_reg         <= '0;
            first_reg       <= '0;
            last_reg        <= '0;
            limit_reg       <= '0;
            need_reg        <= '0;
            tag_reg         <= '0;
            op_reg          <= OP_BAD;
            prod_reg        <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        op_reg    <= q_op;
                        tag_reg   <= q_tag;
                        need_reg  <= q_need;
                        limit_reg <= limit_in;
                        idx_reg   <= '0;
                        run_reg   <= '0;
                        unique case (q_op)
                            OP_ALLOC:
                            begin
                                done_reg  <= 1'b0;
                                state_reg <= S_SCAN;
                            end
                            OP_RELEASE, OP_CLEAR:
                            begin
                                done_reg  <= 1'b0;
                                state_reg <= S_SWEEP;
                            end
                            default:
                            begin
                                done_reg        <= 1'b1;
                                status_reg      <= ST_BAD;
                                address_reg     <= '0;
                                first_block_reg <= '0;
                            end
                        endcase
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    // one block mark a cycle
                    if (idx_reg >= limit_reg || need_reg > limit_reg)
                    begin
                        done_reg        <= 1'b1;
                        status_reg      <= ST_FULL;
                        address_reg     <= '0;
                        first_block_reg <= '0;
                        state_reg       <= S_IDLE;
                    end
                    else if (used_reg[idx_i])
                    begin
                        done_reg <= 1'b0;
                        run_reg  <= '0;
                        idx_reg  <= idx_reg + CW'(1);
                    end
                    else if (run_inc == need_reg)
                    begin
                        done_reg  <= 1'b0;
                        first_reg <= idx_reg + CW'(1) - need_reg;
                        last_reg  <= idx_reg;
                        idx_reg   <= idx_reg + CW'(1) - need_reg;
                        state_reg <= S_MARK;
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                        run_reg  <= run_inc;
                        idx_reg  <= idx_reg + CW'(1);
                    end
                end
                S_MARK:
                begin
                    done_reg        <= 1'b0;
                    used_reg[idx_i] <= 1'b1;
                    idx_reg <= idx_reg + CW'(1);
                    if (idx_reg == last_reg)
                    begin
                        prod_reg  <= 32'(first_reg) * 32'(block_size);
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    done_reg        <= 1'b1;
                    status_reg      <= ST_DONE;
                    address_reg     <= base_address + prod_reg;
                    first_block_reg <= 6'(first_reg);
                    state_reg       <= S_IDLE;
                end
                S_SWEEP:
                begin
                    if (sweep_hit)
                    begin
                        used_reg[idx_i] <= 1'b0;
                    end
                    idx_reg <= idx_reg + CW'(1);
                    if (idx_reg == CW'(MAX_BLOCKS - 1))
                    begin
                        done_reg        <= 1'b1;
                        status_reg      <= ST_DONE;
                        address_reg     <= '0;
                        first_block_reg <= '0;
                        state_reg       <= S_IDLE;
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/contiguous_block_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// first-fit allocator of contiguous runs in a pool of equal blocks
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until its result word is shown, and done marks that word for one cycle with
// no way for the receiver to stall it. An allocate passes through the front
// divider (one quotient bit a cycle), is handed to the queue and popped by the
// back end, which scans one block mark a cycle up to the end of the first
// fitting run, marks the granted blocks one a cycle, adds the base address in
// S_MUL and then shows the word. With no fitting run the scan stops at the end
// of the configured pool. Release and clear sweep all MAX_BLOCKS entries, one
// a cycle. A bad request is answered by the back end without a scan or sweep.
// Pool state starts all free at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_block_allocator
    import cba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64,
    parameter int TAG_BITS   = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command side
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] owner_tag,
    input  wire logic [23:0] request_bytes,
    // result side
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      address,
    output logic [5:0]       first_block,
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // block count width: holds MAX_BLOCKS plus one and any block_count value
    localparam int CW = ($clog2(MAX_BLOCKS + 1) + 1 > 8) ? $clog2(MAX_BLOCKS + 1) + 1 : 8;
    localparam int QW = 2 + TAG_BITS + CW;

    logic [6:0]  block_count_reg;
    logic [15:0] block_size_reg;
    logic [31:0] base_address_reg;

    logic                front_busy;
    logic                back_busy;
    logic                q_full;
    logic                q_push;
    logic                q_pop;
    logic                q_valid;
    op_t                 f_op;
    logic [TAG_BITS-1:0] f_tag;
    logic [CW-1:0]       f_need;
    logic [QW-1:0]       q_out;
    op_t                 b_op;

    // whole item in flight anywhere holds off the next command
    assign busy = front_busy || q_valid || back_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg  <= '0;
            block_size_reg   <= '0;
            base_address_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_COUNT:  block_count_reg  <= cfg_data[6:0];
                REG_BLOCK_SIZE:   block_size_reg   <= cfg_data[15:0];
                REG_BASE_ADDRESS: base_address_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    cba_front #(.TAG_BITS(TAG_BITS), .CW(CW)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start && !busy),
        .front_busy    (front_busy),
        .command       (command),
        .owner_tag     (owner_tag),
        .request_bytes (request_bytes),
        .block_count   (block_count_reg),
        .block_size    (block_size_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_op          (f_op),
        .q_tag         (f_tag),
        .q_need        (f_need)
    );

    cba_queue #(.W(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_op, f_tag, f_need}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    assign b_op = op_t'(q_out[QW-1 -: 2]);

    cba_back #(.MAX_BLOCKS(MAX_BLOCKS), .TAG_BITS(TAG_BITS), .CW(CW)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_op         (b_op),
        .q_tag        (q_out[CW +: TAG_BITS]),
        .q_need       (q_out[CW-1:0]),
        .block_count  (block_count_reg),
        .block_size   (block_size_reg),
        .base_address (base_address_reg),
        .back_busy    (back_busy),
        .done         (done),
        .status       (status),
        .address      (address),
        .first_block  (first_block)
    );

endmodule

`default_nettype wire
